FILE: src/jvm_int_stack_executor_top_assert.svh
// Assertion macros for the stack executor top level
`ifndef JVM_INT_STACK_EXECUTOR_TOP_ASSERT_SVH
`define JVM_INT_STACK_EXECUTOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define JSX_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define JSX_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define JSX_ASSERT_IMPL(label, clk, rst, ante, cons)
`define JSX_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/jsx_pkg.sv
// Package: types, constants and opcodes of the stack executor
`default_nettype none
package jsx_pkg;
  localparam int STACK_DEPTH = 32;
  localparam int NUM_LOCALS  = 16;
  localparam int PC_BITS     = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int SA_W        = $clog2(STACK_DEPTH);
  localparam int LA_W        = $clog2(NUM_LOCALS);

  localparam logic [1:0] OPN_EXEC  = 2'd0;
  localparam logic [1:0] OPN_START = 2'd1;
  localparam logic [1:0] OPN_SETARG = 2'd2;

  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_RET   = 3'd1;
  localparam logic [2:0] ST_UNSUP = 3'd2;
  localparam logic [2:0] ST_OVF   = 3'd3;
  localparam logic [2:0] ST_UNF   = 3'd4;
  localparam logic [2:0] ST_DIV0  = 3'd5;
  localparam logic [2:0] ST_BADL  = 3'd6;

  localparam logic [7:0] OP_NOP = 8'h00, OP_BIPUSH = 8'h10, OP_SIPUSH = 8'h11;
  localparam logic [7:0] OP_ILOAD = 8'h15, OP_ALOAD = 8'h19;
  localparam logic [7:0] OP_ISTORE = 8'h36, OP_ASTORE = 8'h3a;
  localparam logic [7:0] OP_IADD = 8'h60, OP_ISUB = 8'h64, OP_IMUL = 8'h68;
  localparam logic [7:0] OP_IDIV = 8'h6c, OP_INEG = 8'h74, OP_IAND = 8'h7e;
  localparam logic [7:0] OP_IOR = 8'h80, OP_POP = 8'h57, OP_DUP = 8'h59;
  localparam logic [7:0] OP_IINC = 8'h84, OP_IFEQ = 8'h99, OP_IFNE = 8'h9a;
  localparam logic [7:0] OP_IFCMPEQ = 8'h9f, OP_IFCMPNE = 8'ha0, OP_IFCMPLT = 8'ha1;
  localparam logic [7:0] OP_IFCMPGE = 8'ha2, OP_IFCMPGT = 8'ha3, OP_IFCMPLE = 8'ha4;
  localparam logic [7:0] OP_GOTO = 8'ha7, OP_IRETURN = 8'hac, OP_ARETURN = 8'hb0;
  localparam logic [7:0] OP_RETURN = 8'hb1, OP_GETSTATIC = 8'hb2;
  localparam logic [7:0] OP_INVSTATIC = 8'hb8, OP_INVDYN = 8'hba;

  typedef enum logic [3:0] {
    K_NONE, K_PUSH, K_LOAD, K_STORE, K_IINC, K_BIN, K_NEG, K_POP, K_DUP,
    K_IF1, K_IF2, K_GOTO, K_RET, K_UNSUP, K_START, K_SETARG
  } kind_t;

  typedef enum logic [2:0] {
    X_IDLE, X_EXEC, X_DIV, X_OUT
  } xstate_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  opcode;
    logic [7:0]  local_index;
    logic signed [7:0]  byte_immediate;
    logic signed [15:0] wide_immediate;
    logic signed [31:0] arg_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic signed [31:0] top_value;
    logic [5:0]  stack_depth;
    logic [2:0]  status;
  } out_item_t;

  // classified instruction passed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  opcode;
    logic [7:0]  lidx;
    logic [31:0] imm;
    logic [2:0]  pc_step;
    logic [15:0] woff;
  } dec_t;
endpackage
`default_nettype wire

FILE: src/jvm_int_stack_executor_top.sv
// Top level of the integer stack executor
// One word in, one result word out. The front end classifies each word and
// keeps up to two of them queued; the back end executes one word at a time:
// it executes the word and puts the result in the result register, and it
// takes the next word from the queue only once that result is taken. A divide
// runs through the bit-serial divider first. The result register holds a
// finished word while the next one is taken into the queue. Code length is
// taken only while the back end is idle and the queue is empty.
`default_nettype none
`include "jvm_int_stack_executor_top_assert.svh"
module jvm_int_stack_executor_top import jsx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);
  logic [15:0] code_length;
  logic q_valid, q_ready, busy;
  dec_t q_data;

  assign cfg_ready = !busy && !q_valid;
  always_ff @(posedge clk) begin
    if (rst) code_length <= '0;
    else if (cfg_valid && cfg_ready) code_length <= cfg_data;
  end

  jsx_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  jsx_back u_back (
    .clk(clk), .rst(rst), .code_length(code_length), .q_valid(q_valid),
    .q_ready(q_ready), .q_data(q_data), .out_valid(out_valid),
    .out_ready(out_ready), .out_data(out_data), .busy(busy)
  );

  `JSX_ASSERT_IMPL(a_depth_max, clk, rst, out_valid, out_data.stack_depth <= 6'd32)
  `JSX_ASSERT_NEXT(a_hold_out, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `JSX_ASSERT_IMPL(a_status_range, clk, rst, out_valid, out_data.status != 3'd7)
endmodule
`default_nettype wire

FILE: src/jsx_front.sv
// Front end: accept words, classify opcodes, queue them for the back end
`default_nettype none
module jsx_front import jsx_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          q_valid,
  input  wire logic     q_ready,
  output dec_t          q_data
);
  dec_t d;
  dec_t fifo [2];
  logic       wp, rp;
  logic [1:0] cnt;

  always_comb begin
    d = '0;
    d.opcode = in_data.opcode;
    d.lidx = in_data.local_index;
    d.woff = in_data.wide_immediate;
    d.pc_step = 3'd1;
    d.kind = K_NONE;
    case (in_data.operation)
      OPN_START:  d.kind = K_START;
      OPN_SETARG: begin d.kind = K_SETARG; d.imm = in_data.arg_value; end
      OPN_EXEC: begin
        case (in_data.opcode) inside
          // nop: a one-byte skip
          OP_NOP: d.kind = K_GOTO;
          [8'h02:8'h08]: begin
            d.kind = K_PUSH; d.imm = 32'(signed'(9'(in_data.opcode) - 9'd3));
          end
          OP_BIPUSH: begin
            d.kind = K_PUSH; d.imm = 32'(in_data.byte_immediate); d.pc_step = 3'd2;
          end
          OP_SIPUSH: begin
            d.kind = K_PUSH; d.imm = 32'(in_data.wide_immediate); d.pc_step = 3'd3;
          end
          OP_GETSTATIC: begin d.kind = K_PUSH; d.pc_step = 3'd3; end
          OP_ILOAD, OP_ALOAD: begin d.kind = K_LOAD; d.pc_step = 3'd2; end
          [8'h1a:8'h1d]: begin d.kind = K_LOAD; d.lidx = in_data.opcode - 8'h1a; end
          [8'h2a:8'h2d]: begin d.kind = K_LOAD; d.lidx = in_data.opcode - 8'h2a; end
          OP_ISTORE, OP_ASTORE: begin d.kind = K_STORE; d.pc_step = 3'd2; end
          [8'h3b:8'h3e]: begin d.kind = K_STORE; d.lidx = in_data.opcode - 8'h3b; end
          [8'h4b:8'h4e]: begin d.kind = K_STORE; d.lidx = in_data.opcode - 8'h4b; end
          OP_IINC: begin
            d.kind = K_IINC; d.imm = 32'(in_data.byte_immediate); d.pc_step = 3'd3;
          end
          OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_IAND, OP_IOR: d.kind = K_BIN;
          OP_INEG: d.kind = K_NEG;
          OP_POP: d.kind = K_POP;
          OP_DUP: d.kind = K_DUP;
          OP_INVSTATIC: begin d.kind = K_GOTO; d.pc_step = 3'd3; end
          OP_INVDYN: begin d.kind = K_GOTO; d.pc_step = 3'd5; end
          OP_IFEQ, OP_IFNE: begin d.kind = K_IF1; d.pc_step = 3'd3; end
          [OP_IFCMPEQ:OP_IFCMPLE]: begin d.kind = K_IF2; d.pc_step = 3'd3; end
          // goto: step 0 marks an unconditional jump
          OP_GOTO: begin d.kind = K_GOTO; d.pc_step = 3'd0; end
          OP_IRETURN, OP_ARETURN, OP_RETURN: d.kind = K_RET;
          default: d.kind = K_UNSUP;
        endcase
      end
      default: d.kind = K_NONE;
    endcase
  end

  assign in_ready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_data   = fifo[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) fifo[wp] <= d;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (q_valid && q_ready) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end
endmodule
`default_nettype wire

FILE: src/jsx_divider.sv
// Iterative signed 32-bit divider, one quotient bit per cycle
`default_nettype none
module jsx_divider import jsx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  logic [31:0] q, dv;
  logic [32:0] r;
  logic [5:0]  n;
  logic        busy, neg;
  logic [32:0] r_sh, r_sub;

  assign r_sh  = {r[31:0], q[31]};
  assign r_sub = r_sh - {1'b0, dv};
  assign quotient = neg ? 32'(-q) : q;

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend[31] ? -dividend : dividend;
      dv  <= divisor[31] ? -divisor : divisor;
      r   <= '0;
      neg <= dividend[31] ^ divisor[31];
    end else if (busy) begin
      if (!r_sub[32]) begin r <= r_sub; q <= {q[30:0], 1'b1}; end
      else begin r <= r_sh; q <= {q[30:0], 1'b0}; end
    end
    if (rst) begin
      busy <= 1'b0; n <= '0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin busy <= 1'b1; n <= 6'd0; end
      else if (busy) begin
        n <= n + 6'd1;
        if (n == 6'd31) begin busy <= 1'b0; done <= 1'b1; end
      end
    end
  end
endmodule
`default_nettype wire

FILE: src/jsx_back.sv
// Back end: stack, locals, pc and result register
`default_nettype none
module jsx_back import jsx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] code_length,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire dec_t        q_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  output logic             busy
);
  xstate_t state, state_next;
  logic [31:0] stk [STACK_DEPTH];
  logic [31:0] loc [NUM_LOCALS];
  logic [STACK_DEPTH-1:0] stk_v;
  logic [NUM_LOCALS-1:0]  loc_v;
  logic [SP_W-1:0] sp;
  logic [PC_BITS-1:0] pc;
  logic [2:0] halt;
  dec_t cur;

  logic [31:0] a, b, top, lval, res;
  logic [SP_W-1:0] sp_next;
  logic [PC_BITS-1:0] pc_next;
  logic [2:0] status, halt_next;
  logic do_push, do_pop1, do_pop2, do_store, do_iinc, do_set, do_clear, do_div;
  logic lbad, take;
  logic div_start, div_done;
  logic [31:0] div_q;
  logic [31:0] div_a, div_b;
  logic [PC_BITS-1:0] pc_br;

  jsx_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q)
  );

  function automatic logic [31:0] rd_stk(input logic [SP_W-1:0] i,
                                         input logic [31:0] v [STACK_DEPTH],
                                         input logic [STACK_DEPTH-1:0] vb);
    return vb[i[SA_W-1:0]] ? v[i[SA_W-1:0]] : 32'd0;
  endfunction

  assign top  = (sp != '0) ? rd_stk(sp - SP_W'(1), stk, stk_v) : 32'd0;
  assign b    = top;
  assign a    = (sp > SP_W'(1)) ? rd_stk(sp - SP_W'(2), stk, stk_v) : 32'd0;
  assign lbad = cur.lidx >= 8'(NUM_LOCALS);
  assign lval = loc_v[cur.lidx[LA_W-1:0]] ? loc[cur.lidx[LA_W-1:0]] : 32'd0;
  assign pc_br = pc + PC_BITS'(signed'(cur.woff));
  assign div_a = a;
  assign div_b = b;

  always_comb begin
    state_next = state;
    q_ready = 1'b0;
    status = halt; halt_next = halt;
    sp_next = sp; pc_next = pc;
    res = '0;
    do_push = 1'b0; do_pop1 = 1'b0; do_pop2 = 1'b0; do_store = 1'b0;
    do_iinc = 1'b0; do_set = 1'b0; do_clear = 1'b0; do_div = 1'b0;
    div_start = 1'b0; take = 1'b0;
    case (state)
      X_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) state_next = X_EXEC;
      end
      X_EXEC, X_DIV: begin
        state_next = X_OUT;
        case (cur.kind)
          K_START: begin do_clear = 1'b1; status = ST_RUN; end
          K_SETARG: begin
            if (lbad) status = ST_BADL; else do_set = 1'b1;
          end
          K_NONE: ;
          default: if (halt == ST_RUN) begin
            if ({16'd0, pc} >= {16'd0, code_length}) begin
              halt_next = ST_RET; status = ST_RET;
            end else begin
              status = ST_RUN;
              pc_next = pc + PC_BITS'(cur.pc_step);
              case (cur.kind)
                K_PUSH, K_LOAD: begin
                  if (sp == SP_W'(STACK_DEPTH)) status = ST_OVF;
                  else if (cur.kind == K_LOAD && lbad) status = ST_BADL;
                  else begin
                    do_push = 1'b1; sp_next = sp + SP_W'(1);
                    res = (cur.kind == K_LOAD) ? lval : cur.imm;
                  end
                end
                K_STORE: begin
                  if (sp == '0) status = ST_UNF;
                  else if (lbad) status = ST_BADL;
                  else begin do_store = 1'b1; sp_next = sp - SP_W'(1); res = top; end
                end
                K_IINC: begin
                  if (lbad) status = ST_BADL;
                  else begin do_iinc = 1'b1; res = lval + cur.imm; end
                end
                K_BIN: begin
                  if (sp < SP_W'(2)) status = ST_UNF;
                  else if (cur.opcode == OP_IDIV && b == '0) status = ST_DIV0;
                  else begin
                    sp_next = sp - SP_W'(1); do_pop2 = 1'b1;
                    case (cur.opcode)
                      OP_IADD: res = a + b;
                      OP_ISUB: res = a - b;
                      OP_IMUL: res = a * b;
                      OP_IAND: res = a & b;
                      OP_IOR:  res = a | b;
                      default: res = div_q;
                    endcase
                    if (cur.opcode == OP_IDIV) begin
                      do_div = 1'b1;
                      if (state == X_EXEC) begin
                        div_start = 1'b1; state_next = X_DIV;
                        do_pop2 = 1'b0; sp_next = sp; pc_next = pc;
                      end else if (!div_done) begin
                        state_next = X_DIV;
                        do_pop2 = 1'b0; sp_next = sp; pc_next = pc;
                      end
                    end
                  end
                end
                K_NEG: begin
                  if (sp == '0) status = ST_UNF;
                  else begin do_pop1 = 1'b1; res = -top; end
                end
                K_POP: begin
                  if (sp == '0) status = ST_UNF; else sp_next = sp - SP_W'(1);
                end
                K_DUP: begin
                  if (sp == '0) status = ST_UNF;
                  else if (sp == SP_W'(STACK_DEPTH)) status = ST_OVF;
                  else begin do_push = 1'b1; sp_next = sp + SP_W'(1); res = top; end
                end
                K_IF1: begin
                  if (sp == '0) status = ST_UNF;
                  else begin
                    sp_next = sp - SP_W'(1);
                    take = (cur.opcode == OP_IFEQ) ? (top == '0) : (top != '0);
                    if (take) pc_next = pc_br;
                  end
                end
                K_IF2: begin
                  if (sp < SP_W'(2)) status = ST_UNF;
                  else begin
                    sp_next = sp - SP_W'(2);
                    case (cur.opcode)
                      OP_IFCMPEQ: take = a == b;
                      OP_IFCMPNE: take = a != b;
                      OP_IFCMPLT: take = $signed(a) < $signed(b);
                      OP_IFCMPGE: take = $signed(a) >= $signed(b);
                      OP_IFCMPGT: take = $signed(a) > $signed(b);
                      default:    take = $signed(a) <= $signed(b);
                    endcase
                    if (take) pc_next = pc_br;
                  end
                end
                K_GOTO: if (cur.pc_step == 3'd0) pc_next = pc_br;
                K_RET: begin halt_next = ST_RET; status = ST_RET; pc_next = pc; end
                default: begin halt_next = ST_UNSUP; status = ST_UNSUP; pc_next = pc; end
              endcase
              if (status != ST_RUN) begin
                pc_next = pc; sp_next = sp; do_push = 1'b0; do_pop1 = 1'b0;
                do_pop2 = 1'b0; do_store = 1'b0; do_iinc = 1'b0;
              end
            end
          end
        endcase
        if (state_next == X_DIV) status = halt;
      end
      X_OUT: if (out_ready) begin
        q_ready = 1'b1;
        state_next = q_valid ? X_EXEC : X_IDLE;
      end
      default: state_next = X_IDLE;
    endcase
  end

  logic [SP_W-1:0] sp_eff;
  logic [31:0] top_eff;
  always_comb begin
    sp_eff = sp_next;
    top_eff = 32'd0;
    if (do_clear) sp_eff = '0;
    else if (do_push || do_pop1 || do_pop2) top_eff = res;
    else if (sp_next != '0) top_eff = rd_stk(sp_next - SP_W'(1), stk, stk_v);
  end

  logic fin;
  assign fin = (state == X_EXEC || state == X_DIV) && state_next == X_OUT;

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) cur <= q_data;
    if (fin) begin
      out_data.next_pc     <= do_clear ? '0 : 16'(pc_next);
      out_data.top_value   <= top_eff;
      out_data.stack_depth <= 6'(sp_eff);
      out_data.status      <= status;
      if (do_push) stk[sp[SA_W-1:0]] <= res;
      if (do_pop1) stk[SA_W'(sp - SP_W'(1))] <= res;
      if (do_pop2) stk[SA_W'(sp - SP_W'(2))] <= res;
      if (do_store) loc[cur.lidx[LA_W-1:0]] <= top;
      if (do_iinc) loc[cur.lidx[LA_W-1:0]] <= res;
      if (do_set) loc[cur.lidx[LA_W-1:0]] <= cur.imm;
    end
    if (rst) begin
      state <= X_IDLE; sp <= '0; pc <= '0; halt <= ST_RUN;
      stk_v <= '0; loc_v <= '0;
    end else begin
      state <= state_next;
      if (fin) begin
        if (do_clear) begin
          sp <= '0; pc <= '0; halt <= ST_RUN; stk_v <= '0; loc_v <= '0;
        end else begin
          sp <= sp_next; pc <= pc_next; halt <= halt_next;
          if (do_push) stk_v[sp[SA_W-1:0]] <= 1'b1;
          if (do_pop1) stk_v[SA_W'(sp - SP_W'(1))] <= 1'b1;
          if (do_pop2) stk_v[SA_W'(sp - SP_W'(2))] <= 1'b1;
          if (do_store || do_iinc || do_set) loc_v[cur.lidx[LA_W-1:0]] <= 1'b1;
        end
      end
    end
  end

  assign out_valid = (state == X_OUT);
  assign busy = (state != X_IDLE) || do_div;
endmodule
`default_nettype wire
